/* rtl/ssbs_pkg.sv */
// Shared types and constants for the sorted store with binary search.
// No dependencies; imported by the top level.
package ssbs_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 10;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [1:0] ST_APPENDED  = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_FOUND     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_PROBE = 2'b10
  } state_t;

  // Lower middle of the window [lo, hi); only meaningful when hi > lo.
  function automatic logic [ADDR_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] mid;
    span = hi - lo - CNT_W'(1);
    mid  = lo + (span >> 1);
    return mid[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/ssbs_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module ssbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sorted_store_binary_search_top.sv */
// Append-only sorted store with binary search over the filled slots.
// An append answers in the cycle after its request. A search reads one probe per cycle
// through the store RAM read port and answers after the RAM read of its last probe and
// the registered result; an empty-store search answers in the cycle after its request.
// One request at a time; busy is high while a search walks. The receiver cannot stall.
// Synchronous reset empties the store (count to zero); RAM contents are not cleared.
module sorted_store_binary_search_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic signed [31:0]         value,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [ssbs_pkg::POS_W-1:0] position
);

  import ssbs_pkg::*;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          lo;
  logic [CNT_W-1:0]          hi;
  logic [ADDR_W-1:0]         mid;
  logic signed [DATA_W-1:0]  key;

  logic                      we;
  logic [ADDR_W-1:0]         raddr;
  logic [DATA_W-1:0]         rdata;
  logic                      accept;
  logic                      full;
  logic                      hit;
  logic                      below;
  logic [CNT_W-1:0]          lo_next;
  logic [CNT_W-1:0]          hi_next;

  ssbs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign full   = (count == CNT_W'(DEPTH));
  assign we     = accept && (action == ACT_APPEND) && !full;

  assign hit   = ($signed(rdata) == key);
  assign below = ($signed(rdata) < key);

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (below) begin
      lo_next = CNT_W'(mid) + CNT_W'(1);
    end else begin
      hi_next = CNT_W'(mid);
    end
  end

  // The first probe is issued in the request cycle; later probes come from the
  // window narrowed by the data that the RAM returns this cycle.
  always_comb begin
    if (state == S_IDLE) begin
      raddr = mid_of('0, count);
    end else begin
      raddr = mid_of(lo_next, hi_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (action == ACT_APPEND) begin
              done <= 1'b1;
              if (full) begin
                status   <= ST_DROPPED;
                position <= '0;
              end else begin
                status   <= ST_APPENDED;
                position <= POS_W'(count);
                count    <= count + CNT_W'(1);
              end
            end else begin
              key <= value;
              if (count == '0) begin
                done     <= 1'b1;
                status   <= ST_NOT_FOUND;
                position <= '0;
              end else begin
                lo    <= '0;
                hi    <= count;
                mid   <= raddr;
                state <= S_PROBE;
              end
            end
          end
        end
        S_PROBE: begin
          if (hit) begin
            done     <= 1'b1;
            status   <= ST_FOUND;
            position <= POS_W'(mid);
            state    <= S_IDLE;
          end else if (lo_next < hi_next) begin
            lo  <= lo_next;
            hi  <= hi_next;
            mid <= raddr;
          end else begin
            done     <= 1'b1;
            status   <= ST_NOT_FOUND;
            position <= '0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
